// ----- rtl/rmst_pkg.sv -----
// Shared types, codes and helpers for the range-max segment tree.
// No dependencies.
package rmst_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 10;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]         idx_t;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // minus one billion: reset value of every node and empty-range answer
  localparam data_t EMPTY_MAX = 32'shC4653600;

  function automatic data_t smax(input data_t a, input data_t b);
    smax = (a >= b) ? a : b;
  endfunction

endpackage

// ----- rtl/rmst_mem.sv -----
// Node store: one write port, two read ports, registered read data.
// Depends on rmst_pkg.
module rmst_mem #(
  parameter int ADDR_W = 11
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  rmst_pkg::data_t      wdata,
  input  logic [ADDR_W-1:0]    ra_addr,
  input  logic [ADDR_W-1:0]    rb_addr,
  output rmst_pkg::data_t      ra_data,
  output rmst_pkg::data_t      rb_data
);

  rmst_pkg::data_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

// ----- rtl/rmst_walk.sv -----
// Tree walker: clearing pass, leaf-to-root update, two-ended query walk.
// Depends on rmst_pkg; drives the ports of rmst_mem.
module rmst_walk #(
  parameter int LEAF_COUNT = 1024,
  parameter int NW         = $clog2(LEAF_COUNT) + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  mode,
  input  rmst_pkg::idx_t        leaf_index,
  input  rmst_pkg::idx_t        right_index,
  input  rmst_pkg::data_t       new_value,
  input  logic                  res_ready,
  output logic                  res_valid,
  output rmst_pkg::data_t       res_data,
  output logic                  mem_we,
  output logic [NW-1:0]         mem_waddr,
  output rmst_pkg::data_t       mem_wdata,
  output logic [NW-1:0]         mem_ra_addr,
  output logic [NW-1:0]         mem_rb_addr,
  input  rmst_pkg::data_t       mem_ra_data,
  input  rmst_pkg::data_t       mem_rb_data
);

  localparam int LW = NW - 1;
  localparam int XW = ((LW > rmst_pkg::IDX_W) ? LW : rmst_pkg::IDX_W) + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_QRY,
    ST_FIN
  } state_t;

  state_t          state;
  logic [NW-1:0]   clr_cnt;
  logic [NW-1:0]   upd_k;
  rmst_pkg::data_t cur;
  logic [NW:0]     lo;
  logic [NW:0]     hi;
  logic            vld_a;
  logic            vld_b;
  rmst_pkg::data_t best;
  logic            found;

  logic [XW-1:0]   leaf_x;
  logic [XW-1:0]   right_x;
  logic [XW-1:0]   lc_x;
  logic            leaf_ok;
  logic [LW-1:0]   right_sat;
  logic [NW-1:0]   leaf_n;
  logic            acc;
  logic [NW-1:0]   par;
  rmst_pkg::data_t cur_next;
  logic            active;
  logic            take_lo;
  logic            take_hi;
  logic [NW:0]     lo_next;
  logic [NW:0]     hi_next;
  rmst_pkg::data_t pair_max;
  rmst_pkg::data_t best_next;

  assign in_stall  = (state != ST_IDLE);
  assign acc       = in_valid && !in_stall;

  assign leaf_x    = XW'(leaf_index);
  assign right_x   = XW'(right_index);
  assign lc_x      = XW'(LEAF_COUNT);
  assign leaf_ok   = (leaf_x < lc_x);
  assign right_sat = (right_x >= lc_x) ? '1 : right_x[LW-1:0];
  assign leaf_n    = {1'b1, leaf_x[LW-1:0]};

  assign par       = upd_k >> 1;
  assign cur_next  = rmst_pkg::smax(cur, mem_ra_data);

  assign active    = (lo <= hi);
  assign take_lo   = active && lo[0];
  assign take_hi   = active && !hi[0];
  assign lo_next   = (lo + (NW+1)'(take_lo)) >> 1;
  assign hi_next   = (hi - (NW+1)'(take_hi)) >> 1;

  always_comb begin
    if (vld_a && vld_b) begin
      pair_max = rmst_pkg::smax(mem_ra_data, mem_rb_data);
    end else if (vld_a) begin
      pair_max = mem_ra_data;
    end else begin
      pair_max = mem_rb_data;
    end
    best_next = found ? rmst_pkg::smax(best, pair_max) : pair_max;
  end

  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = clr_cnt;
    mem_wdata   = rmst_pkg::EMPTY_MAX;
    mem_ra_addr = lo[NW-1:0];
    mem_rb_addr = hi[NW-1:0];
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        if (acc && mode == rmst_pkg::MODE_UPDATE && leaf_ok) begin
          mem_we      = 1'b1;
          mem_waddr   = leaf_n;
          mem_wdata   = new_value;
          mem_ra_addr = leaf_n ^ NW'(1);
        end
      end
      ST_UPD: begin
        mem_we      = 1'b1;
        mem_waddr   = par;
        mem_wdata   = cur_next;
        mem_ra_addr = par ^ NW'(1);
      end
      ST_QRY, ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  assign res_valid = (state == ST_FIN) && res_ready;
  assign res_data  = found ? best : rmst_pkg::EMPTY_MAX;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      vld_a   <= 1'b0;
      vld_b   <= 1'b0;
      found   <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + NW'(1);
          if (clr_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc) begin
            if (mode == rmst_pkg::MODE_UPDATE) begin
              if (leaf_ok) begin
                upd_k <= leaf_n;
                cur   <= new_value;
                state <= ST_UPD;
              end
            end else begin
              lo    <= leaf_ok ? {1'b0, leaf_n} : {1'b1, NW'(0)};
              hi    <= {2'b01, right_sat};
              vld_a <= 1'b0;
              vld_b <= 1'b0;
              found <= 1'b0;
              state <= ST_QRY;
            end
          end
        end
        ST_UPD: begin
          upd_k <= par;
          cur   <= cur_next;
          if (par == NW'(1)) begin
            state <= ST_IDLE;
          end
        end
        ST_QRY: begin
          // ends hold once they cross
          if (active) begin
            lo <= lo_next;
            hi <= hi_next;
          end
          vld_a <= take_lo;
          vld_b <= take_hi;
          if (vld_a || vld_b) begin
            best  <= best_next;
            found <= 1'b1;
          end
          if (!active && !vld_a && !vld_b) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_qry_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QRY || state == ST_FIN) |-> !mem_we)
    else $error("tree written during a query");

  a_upd_below_root: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> (upd_k > NW'(1)))
    else $error("update walk past the root");

  a_qry_start: assert property (@(posedge clk) disable iff (rst)
    (acc && mode == rmst_pkg::MODE_QUERY) |=> (state == ST_QRY && !found))
    else $error("query request not started cleanly");

  a_result_only_query: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(state == ST_QRY || state == ST_FIN))
    else $error("result without a query walk");

endmodule

// ----- rtl/range_max_segment_tree.sv -----
// Range-max segment tree, top level: walker, node store, output register.
// Depends on rmst_pkg, rmst_mem, rmst_walk.
// Update: one tree level per cycle, no result.
// Query: result registered into range_max with out_valid set; both range ends
//   read per level through two read ports.
// Reset clears every node of the store in one sweep; no request
//   is taken until it ends.
module range_max_segment_tree #(
  parameter int LEAF_COUNT = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   mode,
  input  logic [9:0]             leaf_index,
  input  logic [9:0]             right_index,
  input  logic signed [31:0]     new_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     range_max
);

  localparam int NW = $clog2(LEAF_COUNT) + 1;

  logic            res_ready;
  logic            res_valid;
  rmst_pkg::data_t res_data;
  logic            mem_we;
  logic [NW-1:0]   mem_waddr;
  rmst_pkg::data_t mem_wdata;
  logic [NW-1:0]   mem_ra_addr;
  logic [NW-1:0]   mem_rb_addr;
  rmst_pkg::data_t mem_ra_data;
  rmst_pkg::data_t mem_rb_data;

  assign res_ready = !out_valid || !out_stall;

  rmst_walk #(
    .LEAF_COUNT (LEAF_COUNT),
    .NW         (NW)
  ) u_walk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .leaf_index  (leaf_index),
    .right_index (right_index),
    .new_value   (new_value),
    .res_ready   (res_ready),
    .res_valid   (res_valid),
    .res_data    (res_data),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_ra_addr (mem_ra_addr),
    .mem_rb_addr (mem_rb_addr),
    .mem_ra_data (mem_ra_data),
    .mem_rb_data (mem_rb_data)
  );

  rmst_mem #(
    .ADDR_W (NW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .ra_addr (mem_ra_addr),
    .rb_addr (mem_rb_addr),
    .ra_data (mem_ra_data),
    .rb_data (mem_rb_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      range_max <= res_data;
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for range_max_segment_tree: point updates and range-max queries
// checked against a software segment tree with random idling on both sides.
// Depends on rmst_pkg and the range_max_segment_tree RTL.
module testbench;

  localparam int LEAVES = 1024;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic            mode = rmst_pkg::MODE_UPDATE;
  rmst_pkg::idx_t  leaf_index = '0;
  rmst_pkg::idx_t  right_index = '0;
  rmst_pkg::data_t new_value = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  rmst_pkg::data_t range_max;

  rmst_pkg::data_t tree_nodes [2*LEAVES];
  rmst_pkg::data_t max_queue [$];
  int    fail_count = 0;
  int    long_hold = 0;
  bit    src_idle_en = 1'b1;
  bit    sink_idle_en = 1'b1;

  range_max_segment_tree #(.LEAF_COUNT(LEAVES)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .leaf_index(leaf_index),
    .right_index(right_index),
    .new_value(new_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .range_max(range_max)
  );

  always #6 clk = ~clk;

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // software tree: leaf i at node LEAVES+i, node k = max(2k, 2k+1)
  function automatic void tree_write(input rmst_pkg::idx_t leaf,
                                     input rmst_pkg::data_t value);
    int k;
    k = int'(leaf) + LEAVES;
    tree_nodes[k] = value;
    for (k = k / 2; k > 0; k = k / 2)
      tree_nodes[k] = (tree_nodes[2*k] >= tree_nodes[2*k+1]) ?
                      tree_nodes[2*k] : tree_nodes[2*k+1];
  endfunction

  function automatic rmst_pkg::data_t tree_max(input rmst_pkg::idx_t left,
                                               input rmst_pkg::idx_t right);
    int              lo;
    int              hi;
    rmst_pkg::data_t best;
    bit              found;
    best = rmst_pkg::EMPTY_MAX;
    found = 1'b0;
    if (left > right) return rmst_pkg::EMPTY_MAX;
    lo = int'(left) + LEAVES;
    hi = int'(right) + LEAVES;
    while (lo <= hi) begin
      if (lo % 2 == 1) begin
        best = (!found || tree_nodes[lo] > best) ? tree_nodes[lo] : best;
        found = 1'b1;
        lo++;
      end
      if (hi % 2 == 0) begin
        best = (!found || tree_nodes[hi] > best) ? tree_nodes[hi] : best;
        found = 1'b1;
        hi--;
      end
      lo = lo / 2;
      hi = hi / 2;
    end
    return best;
  endfunction

  function automatic rmst_pkg::data_t rand_value();
    case ($urandom_range(0, 5))
      0: return rmst_pkg::EMPTY_MAX + rmst_pkg::data_t'($urandom_range(0, 6)) - 3;
      1: return rmst_pkg::data_t'($urandom_range(0, 3) == 0 ? 32'h8000_0000
                                                           : 32'h7FFF_FFFF);
      2: return rmst_pkg::data_t'($urandom_range(0, 200)) - 100;
      default: return rmst_pkg::data_t'($urandom);
    endcase
  endfunction

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_request(input logic op, input rmst_pkg::idx_t left,
                              input rmst_pkg::idx_t right,
                              input rmst_pkg::data_t value);
    int   gap;
    logic stalled;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= op;
    leaf_index  <= left;
    right_index <= right;
    new_value   <= value;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    if (op == rmst_pkg::MODE_QUERY)
      max_queue.push_back(tree_max(left, right));
    else
      tree_write(left, value);
  endtask

  task automatic send_random_request();
    rmst_pkg::idx_t left;
    rmst_pkg::idx_t right;
    int             span;
    if ($urandom_range(0, 99) < 45) begin
      left = ($urandom_range(0, 1) == 0) ? rmst_pkg::idx_t'($urandom_range(0, 63))
                                         : rmst_pkg::idx_t'($urandom_range(0, LEAVES-1));
      send_request(rmst_pkg::MODE_UPDATE, left, rmst_pkg::idx_t'($urandom), rand_value());
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          left = rmst_pkg::idx_t'($urandom_range(0, LEAVES-1));
          right = left;
        end
        1: begin
          left = rmst_pkg::idx_t'($urandom_range(0, LEAVES-1));
          span = int'(left) + $urandom_range(0, 20);
          right = rmst_pkg::idx_t'((span > LEAVES-1) ? LEAVES-1 : span);
        end
        2: begin
          left = rmst_pkg::idx_t'($urandom_range(0, LEAVES-1));
          right = rmst_pkg::idx_t'($urandom_range(0, LEAVES-1));
        end
        default: begin
          left = rmst_pkg::idx_t'($urandom_range(0, 63));
          right = rmst_pkg::idx_t'($urandom_range(0, 63));
        end
      endcase
      send_request(rmst_pkg::MODE_QUERY, left, right, rmst_pkg::data_t'($urandom));
    end
  endtask

  // sender holds off until every result is back, plus the update latency
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (max_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (max_queue.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result at %0t: got %0d", $time, range_max);
        fail_count++;
      end else begin
        if (range_max !== max_queue[0]) begin
          if (fail_count < 10)
            $display("range_max mismatch at %0t: expected %0d, got %0d",
                     $time, max_queue[0], range_max);
          fail_count++;
        end
        void'(max_queue.pop_front());
      end
    end
  end

  always begin
    @(posedge clk);
    if (long_hold > 0) begin
      out_stall <= 1'b1;
      repeat (long_hold) @(posedge clk);
      long_hold = 0;
      out_stall <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  task automatic test_fresh_tree();
    send_request(rmst_pkg::MODE_QUERY, 10'd0, 10'd1023, rmst_pkg::data_t'($urandom));
    send_request(rmst_pkg::MODE_QUERY, 10'd7, 10'd7, rmst_pkg::data_t'($urandom));
    send_request(rmst_pkg::MODE_QUERY, 10'd10, 10'd3, rmst_pkg::data_t'($urandom));
    send_request(rmst_pkg::MODE_QUERY, 10'd1023, 10'd0, rmst_pkg::data_t'($urandom));
    wait_for_results();
  endtask

  task automatic test_extremes();
    send_request(rmst_pkg::MODE_UPDATE, 10'd0, rmst_pkg::idx_t'($urandom),
                 rmst_pkg::data_t'(32'h8000_0000));
    send_request(rmst_pkg::MODE_UPDATE, 10'd1023, rmst_pkg::idx_t'($urandom),
                 rmst_pkg::data_t'(32'h7FFF_FFFF));
    send_request(rmst_pkg::MODE_UPDATE, 10'h2AA, rmst_pkg::idx_t'($urandom),
                 rmst_pkg::data_t'(0));
    send_request(rmst_pkg::MODE_UPDATE, 10'h155, rmst_pkg::idx_t'($urandom),
                 rmst_pkg::data_t'(-1));
    send_request(rmst_pkg::MODE_UPDATE, 10'd512, rmst_pkg::idx_t'($urandom),
                 rmst_pkg::EMPTY_MAX - 1);
    send_request(rmst_pkg::MODE_QUERY, 10'd0, 10'd0, rmst_pkg::data_t'($urandom));
    send_request(rmst_pkg::MODE_QUERY, 10'd0, 10'd1, rmst_pkg::data_t'($urandom));
    send_request(rmst_pkg::MODE_QUERY, 10'd0, 10'd1023, rmst_pkg::data_t'($urandom));
    send_request(rmst_pkg::MODE_QUERY, 10'h155, 10'h2AA, rmst_pkg::data_t'($urandom));
    send_request(rmst_pkg::MODE_QUERY, 10'd512, 10'd512, rmst_pkg::data_t'($urandom));
    send_request(rmst_pkg::MODE_QUERY, 10'd1023, 10'd1023, rmst_pkg::data_t'($urandom));
    send_request(rmst_pkg::MODE_UPDATE, 10'd1023, rmst_pkg::idx_t'($urandom),
                 rmst_pkg::data_t'(-7));
    send_request(rmst_pkg::MODE_QUERY, 10'd0, 10'd1023, rmst_pkg::data_t'($urandom));
    send_request(rmst_pkg::MODE_QUERY, 10'h155, 10'h155, rmst_pkg::data_t'($urandom));
    send_request(rmst_pkg::MODE_QUERY, 10'd0, 10'd340, rmst_pkg::data_t'($urandom));
    wait_for_results();
  endtask

  task automatic test_random_mix();
    repeat (620) send_random_request();
    wait_for_results();
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    long_hold = 400;
    repeat (40) send_random_request();
    wait_for_results();
  endtask

  task automatic test_full_rate();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    repeat (270) send_random_request();
    wait_for_results();
  endtask

  initial begin
    for (int i = 0; i < 2*LEAVES; i++) tree_nodes[i] = rmst_pkg::EMPTY_MAX;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fresh_tree();
    test_extremes();
    test_random_mix();
    test_backpressure();
    test_full_rate();
    if (fail_count == 0 && max_queue.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rmst_pkg.sv
rtl/rmst_mem.sv
rtl/rmst_walk.sv
rtl/range_max_segment_tree.sv
bench/testbench.sv
